// ----- design/bpt_pkg.sv -----
// ----------------------------------------------------------------------------
// Ballast position tracker package
// Shared widths, direction codes, item codes and the tracker state record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpt_pkg;

    localparam int SENSOR_WIDTH = 16;
    localparam int COUNT_WIDTH  = 16;
    localparam int BIT_SEL_W    = 4;
    localparam int FRAC_W       = 17;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX      = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] POSITION_RESET = COUNT_WIDTH'(10);
    localparam logic [FRAC_W-1:0]      FRAC_FULL      = FRAC_W'(65536);

    localparam logic [15:0]          PPF_RESET       = 16'd435;
    localparam logic [BIT_SEL_W-1:0] OPTO_BIT_RESET  = 4'd0;
    localparam logic [BIT_SEL_W-1:0] ENDSTOP_BIT_RESET = 4'd1;

    // Reciprocal of ten in Q19, exact for operands below 2^17.
    localparam logic [15:0] RECIP_TEN = 16'd52429;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULSES_PER_FILL = 2'd0,
        CFG_OPTO_BIT        = 2'd1,
        CFG_ENDSTOP_BIT     = 2'd2
    } cfg_index_t;

    typedef enum logic {
        FUNC_SET_TARGET = 1'b0,
        FUNC_SENSOR     = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        DIR_IDLE  = 2'd0,
        DIR_FILL  = 2'd1,
        DIR_EMPTY = 2'd2
    } dir_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0]  goal;
        logic [COUNT_WIDTH-1:0]  position;
        dir_t                    motion_dir;
        dir_t                    prior_dir;
        logic                    full_flag;
        logic                    empty_flag;
        logic                    initialized;
        logic [SENSOR_WIDTH-1:0] last_sensor;
        logic                    first_endstop_seen;
    } track_state_t;

    typedef struct packed {
        logic [15:0] ppf;
        logic [15:0] ppf_tenth;
        logic [15:0] ppf_nine_tenths;
        logic [BIT_SEL_W-1:0] opto_bit;
        logic [BIT_SEL_W-1:0] endstop_bit;
    } track_cfg_t;

endpackage

// ----- design/bpt_update.sv -----
// ----------------------------------------------------------------------------
// Ballast position tracker update logic
// Computes the tracker state that follows one item from the present state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpt_update (
    input  bpt_pkg::track_cfg_t                 cfg,
    input  bpt_pkg::track_state_t               cur,
    input  logic                                func,
    input  logic [bpt_pkg::FRAC_W-1:0]          target_fraction,
    input  logic [bpt_pkg::SENSOR_WIDTH-1:0]    sensor_bits,
    output bpt_pkg::track_state_t               nxt
);
    import bpt_pkg::*;

    function automatic logic line_bit(input logic [SENSOR_WIDTH-1:0] word,
                                      input logic [BIT_SEL_W-1:0] sel);
        logic result;
        result = 1'b0;
        if (32'(sel) < SENSOR_WIDTH) begin
            result = word[sel];
        end
        return result;
    endfunction

    logic [FRAC_W-1:0] frac_clamped;
    logic [32:0]       goal_product;
    logic [COUNT_WIDTH-1:0] goal_value;
    logic opto_edge;
    logic endstop;

    always_comb begin
        frac_clamped = (target_fraction > FRAC_FULL) ? FRAC_FULL : target_fraction;
        goal_product = 33'(frac_clamped) * 33'(cfg.ppf) + 33'd32768;
        goal_value   = COUNT_WIDTH'(goal_product[32:16]);
        opto_edge    = line_bit(cur.last_sensor ^ sensor_bits, cfg.opto_bit);
        endstop      = line_bit(sensor_bits, cfg.endstop_bit);
    end

    always_comb begin
        nxt = cur;
        if (func == FUNC_SET_TARGET) begin
            nxt.goal = goal_value;
            if (goal_value > cur.position) begin
                if (nxt.motion_dir != DIR_FILL) nxt.prior_dir = nxt.motion_dir;
                nxt.motion_dir = DIR_FILL;
            end else if (goal_value < cur.position) begin
                if (nxt.motion_dir != DIR_EMPTY) nxt.prior_dir = nxt.motion_dir;
                nxt.motion_dir = DIR_EMPTY;
            end else begin
                if (nxt.motion_dir != DIR_IDLE) nxt.prior_dir = nxt.motion_dir;
                nxt.motion_dir = DIR_IDLE;
            end
        end else if (cur.initialized) begin
            nxt.last_sensor = sensor_bits;
            if (opto_edge) begin
                if (cur.motion_dir == DIR_FILL) begin
                    if (nxt.position < COUNT_MAX) nxt.position = nxt.position + 1'b1;
                    if (nxt.position >= cur.goal) begin
                        nxt.prior_dir  = nxt.motion_dir;
                        nxt.motion_dir = DIR_IDLE;
                    end
                end else if (cur.motion_dir == DIR_EMPTY) begin
                    if (nxt.position != '0) nxt.position = nxt.position - 1'b1;
                    if (nxt.position <= cur.goal) begin
                        nxt.prior_dir  = nxt.motion_dir;
                        nxt.motion_dir = DIR_IDLE;
                    end
                end else if (cur.prior_dir == DIR_FILL) begin
                    if (nxt.position < cfg.ppf) nxt.position = nxt.position + 1'b1;
                end else if (cur.prior_dir == DIR_EMPTY) begin
                    if (nxt.position != '0) nxt.position = nxt.position - 1'b1;
                end
            end
            if (!endstop) nxt.first_endstop_seen = 1'b0;
            if (nxt.motion_dir != DIR_IDLE) begin
                if (!endstop) begin
                    nxt.full_flag  = 1'b0;
                    nxt.empty_flag = 1'b0;
                end else if (!(cur.full_flag || cur.empty_flag)) begin
                    if (nxt.first_endstop_seen || nxt.position < cfg.ppf_tenth ||
                        nxt.position > cfg.ppf_nine_tenths) begin
                        nxt.prior_dir  = nxt.motion_dir;
                        nxt.motion_dir = DIR_IDLE;
                        if (nxt.position > (cfg.ppf >> 1)) begin
                            nxt.position  = cfg.ppf;
                            nxt.full_flag = 1'b1;
                        end else begin
                            nxt.position   = '0;
                            nxt.empty_flag = 1'b1;
                        end
                    end else begin
                        nxt.first_endstop_seen = 1'b1;
                    end
                end
            end
        end else begin
            nxt.last_sensor = sensor_bits;
            if (cur.motion_dir != DIR_IDLE) begin
                if (!endstop) begin
                    nxt.full_flag  = 1'b0;
                    nxt.empty_flag = 1'b0;
                end else if (!(cur.full_flag || cur.empty_flag)) begin
                    if (cur.motion_dir == DIR_FILL) begin
                        nxt.position   = cfg.ppf;
                        nxt.prior_dir  = cur.motion_dir;
                        nxt.motion_dir = DIR_IDLE;
                        nxt.full_flag  = 1'b1;
                    end else if (cur.motion_dir == DIR_EMPTY) begin
                        nxt.position    = '0;
                        nxt.prior_dir   = cur.motion_dir;
                        nxt.motion_dir  = DIR_IDLE;
                        nxt.empty_flag  = 1'b1;
                        nxt.initialized = 1'b1;
                    end
                end
            end
        end
    end

endmodule

// ----- design/ballast_position_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// Ballast position tracker
// Counts opto encoder edges, recalibrates at the endstops and drives the
// fill and empty motor lines toward a target set as a Q16 fraction.
// ----------------------------------------------------------------------------
// Each item is held in the input registers and its result in the output
// registers; one item per cycle unless m_ready stalls the output. The state
// update is combinational through the multiplier and compare logic between
// the input and result registers. Reset (synchronous, active low) empties
// both stages, restores register defaults, sets position to ten pulses, idle.
`timescale 1ns / 1ps

module ballast_position_tracker_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [bpt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bpt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_func,
    input  logic [bpt_pkg::FRAC_W-1:0]         s_target_fraction,
    input  logic [bpt_pkg::SENSOR_WIDTH-1:0]   s_sensor_bits,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [bpt_pkg::COUNT_WIDTH-1:0]    m_pulse_count,
    output logic [bpt_pkg::COUNT_WIDTH-1:0]    m_target_pulses,
    output logic                               m_fill_drive,
    output logic                               m_empty_drive,
    output logic                               m_is_moving,
    output logic                               m_init_done,
    output logic                               m_at_full,
    output logic                               m_at_empty
);
    import bpt_pkg::*;

    track_cfg_t   cfg_reg;
    track_state_t state_reg;
    track_state_t state_next;

    logic                    in_valid_reg;
    logic                    in_func_reg;
    logic [FRAC_W-1:0]       in_frac_reg;
    logic [SENSOR_WIDTH-1:0] in_sensor_reg;
    logic                    advance;

    logic [32:0] tenth_prod;
    logic [32:0] tenth_up_prod;

    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign tenth_prod    = 33'(cfg_wdata) * 33'(RECIP_TEN);
    assign tenth_up_prod = (33'(cfg_wdata) + 33'd9) * 33'(RECIP_TEN);

    bpt_update u_update (
        .cfg             (cfg_reg),
        .cur             (state_reg),
        .func            (in_func_reg),
        .target_fraction (in_frac_reg),
        .sensor_bits     (in_sensor_reg),
        .nxt             (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ppf             <= PPF_RESET;
            cfg_reg.ppf_tenth       <= 16'(PPF_RESET / 10);
            cfg_reg.ppf_nine_tenths <= 16'((PPF_RESET * 9) / 10);
            cfg_reg.opto_bit        <= OPTO_BIT_RESET;
            cfg_reg.endstop_bit     <= ENDSTOP_BIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PULSES_PER_FILL: begin
                    cfg_reg.ppf             <= cfg_wdata;
                    cfg_reg.ppf_tenth       <= 16'(tenth_prod[32:19]);
                    cfg_reg.ppf_nine_tenths <= cfg_wdata - 16'(tenth_up_prod[32:19]);
                end
                CFG_OPTO_BIT: begin
                    cfg_reg.opto_bit <= cfg_wdata[BIT_SEL_W-1:0];
                end
                CFG_ENDSTOP_BIT: begin
                    cfg_reg.endstop_bit <= cfg_wdata[BIT_SEL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_func_reg   <= s_func;
            in_frac_reg   <= s_target_fraction;
            in_sensor_reg <= s_sensor_bits;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.goal               <= '0;
            state_reg.position           <= POSITION_RESET;
            state_reg.motion_dir         <= DIR_IDLE;
            state_reg.prior_dir          <= DIR_IDLE;
            state_reg.full_flag          <= 1'b0;
            state_reg.empty_flag         <= 1'b0;
            state_reg.initialized        <= 1'b0;
            state_reg.last_sensor        <= '0;
            state_reg.first_endstop_seen <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (advance) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
        if (advance) begin
            m_pulse_count   <= state_next.position;
            m_target_pulses <= state_next.goal;
            m_fill_drive    <= (state_next.motion_dir == DIR_FILL);
            m_empty_drive   <= (state_next.motion_dir == DIR_EMPTY);
            m_is_moving     <= (state_next.motion_dir != DIR_IDLE);
            m_init_done     <= state_next.initialized;
            m_at_full       <= state_next.full_flag;
            m_at_empty      <= state_next.empty_flag;
        end
    end

endmodule
